>>> src/deq_pkg.sv
package deq_pkg;

   localparam int DEPTH    = 16;
   localparam int PTR_W    = $clog2(DEPTH);
   localparam int OCC_W    = $clog2(DEPTH + 1);
   localparam int SUM_W    = OCC_W + 1;

   localparam int MODE_W   = 2;
   localparam int VALUE_W  = 32;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 2;

   localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PUSH_REAR  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_POP_REAR   = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_POP_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_PUSH_FULL = 2'd2;

   typedef logic [MODE_W-1:0]          mode_type;
   typedef logic signed [VALUE_W-1:0]  value_type;
   typedef logic [COUNT_W-1:0]         count_type;
   typedef logic [STATUS_W-1:0]        status_type;

endpackage

>>> src/deq_if.sv
interface deq_req_if;
   import deq_pkg::*;

   logic      valid;
   logic      ready;
   mode_type  mode;
   value_type value;

   modport source (output valid, output mode, output value, input ready);
   modport sink   (input valid, input mode, input value, output ready);
endinterface

interface deq_rsp_if;
   import deq_pkg::*;

   logic       valid;
   logic       ready;
   value_type  front_value;
   value_type  rear_value;
   count_type  count;
   status_type status;

   modport source (output valid, output front_value, output rear_value,
                   output count, output status, input ready);
   modport sink   (input valid, input front_value, input rear_value,
                   input count, input status, output ready);
endinterface

>>> src/deq_ram.sv
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem_ff[rd_addr_a];
         rd_data_b <= mem_ff[rd_addr_b];
      end
   end

endmodule

>>> src/double_ended_queue.sv
// Double-ended queue of signed 32-bit values held in a 16-slot circular
// buffer RAM, addressed by a front pointer and an occupancy count. Each req
// item pushes at the front, pushes at the rear, pops the front or pops the
// rear; each gives exactly one rsp item with the front and rear values after
// the operation (0 when empty), the count and a status (done, pop on empty
// ignored, push on full dropped). An item goes from accept to result in order:
// the slot write and pointer update at accept, a registered two-port read of
// the new front and rear slots, then the capture into the output register once
// it is free. No new item is accepted until the last one has been captured, so
// a result waiting on rsp holds off the next accept. The slots need no clearing
// after reset.
module double_ended_queue (
   input  logic       clock,
   input  logic       reset,
   deq_req_if.sink    req,
   deq_rsp_if.source  rsp
);
   import deq_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;

   // Reduce a pointer sum known to stay below twice the depth.
   function automatic logic [PTR_W-1:0] wrap_sum(input logic [SUM_W-1:0] s);
      if (s >= SUM_W'(DEPTH)) begin
         return PTR_W'(s - SUM_W'(DEPTH));
      end
      return PTR_W'(s);
   endfunction

   logic [1:0]       state_ff, state_in;
   logic [PTR_W-1:0] fp_ff, fp_in;
   logic [OCC_W-1:0] occ_ff, occ_in;
   status_type       stat_ff, stat_in;

   logic             rsp_valid_ff, rsp_valid_in;
   value_type        front_ff, front_in;
   value_type        rear_ff, rear_in;
   count_type        count_ff, count_in;
   status_type       rsp_stat_ff, rsp_stat_in;

   logic             accept;
   logic             capture;
   logic             q_empty;
   logic             q_full;
   logic [PTR_W-1:0] fp_dec;
   logic [PTR_W-1:0] fp_inc;
   logic [PTR_W-1:0] tail_idx;
   logic [PTR_W-1:0] rear_idx;

   logic               wr_en;
   logic [PTR_W-1:0]   wr_addr;
   logic [VALUE_W-1:0] rd_a;
   logic [VALUE_W-1:0] rd_b;

   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;
   assign capture   = (state_ff == ST_WAIT) && (!rsp_valid_ff || rsp.ready);

   assign q_empty  = (occ_ff == '0);
   assign q_full   = (occ_ff == OCC_W'(DEPTH));
   assign fp_dec   = (fp_ff == '0) ? PTR_W'(DEPTH - 1) : fp_ff - 1'b1;
   assign fp_inc   = (fp_ff == PTR_W'(DEPTH - 1)) ? '0 : fp_ff + 1'b1;
   assign tail_idx = wrap_sum(SUM_W'(fp_ff) + SUM_W'(occ_ff));
   // Rear slot of the updated queue; only meaningful when not empty.
   assign rear_idx = q_empty ? fp_ff
                             : wrap_sum(SUM_W'(fp_ff) + SUM_W'(occ_ff) - 1'b1);

   // Apply the operation at accept: update pointers, write the pushed item.
   always_comb begin
      fp_in   = fp_ff;
      occ_in  = occ_ff;
      stat_in = stat_ff;
      wr_en   = 1'b0;
      wr_addr = tail_idx;
      if (accept) begin
         stat_in = STATUS_DONE;
         unique case (req.mode)
            MODE_PUSH_FRONT: begin
               if (q_full) begin
                  stat_in = STATUS_PUSH_FULL;
               end else begin
                  fp_in   = fp_dec;
                  occ_in  = occ_ff + 1'b1;
                  wr_en   = 1'b1;
                  wr_addr = fp_dec;
               end
            end
            MODE_PUSH_REAR: begin
               if (q_full) begin
                  stat_in = STATUS_PUSH_FULL;
               end else begin
                  occ_in = occ_ff + 1'b1;
                  wr_en  = 1'b1;
               end
            end
            MODE_POP_FRONT: begin
               if (q_empty) begin
                  stat_in = STATUS_POP_EMPTY;
               end else begin
                  fp_in  = fp_inc;
                  occ_in = occ_ff - 1'b1;
               end
            end
            MODE_POP_REAR: begin
               if (q_empty) begin
                  stat_in = STATUS_POP_EMPTY;
               end else begin
                  occ_in = occ_ff - 1'b1;
               end
            end
            default: begin
               stat_in = STATUS_DONE;
            end
         endcase
      end
   end

   // Sequence: write at accept, read the next cycle, capture after that.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (capture) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Load the output register; drop valid once the item is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      front_in     = front_ff;
      rear_in      = rear_ff;
      count_in     = count_ff;
      rsp_stat_in  = rsp_stat_ff;
      if (capture) begin
         rsp_valid_in = 1'b1;
         front_in     = q_empty ? '0 : value_type'(rd_a);
         rear_in      = q_empty ? '0 : value_type'(rd_b);
         count_in     = COUNT_W'(occ_ff);
         rsp_stat_in  = stat_ff;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   deq_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (req.value),
      .rd_en     (state_ff == ST_READ),
      .rd_addr_a (fp_ff),
      .rd_addr_b (rear_idx),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fp_ff        <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fp_ff        <= fp_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stat_ff     <= stat_in;
      front_ff    <= front_in;
      rear_ff     <= rear_in;
      count_ff    <= count_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.front_value = front_ff;
   assign rsp.rear_value  = rear_ff;
   assign rsp.count       = count_ff;
   assign rsp.status      = rsp_stat_ff;

endmodule

>>> tb/sv/deque_checker.sv
`timescale 1ns / 1ps

module deque_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  deq_pkg::mode_type   req_mode,
   input  deq_pkg::value_type  req_value,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  deq_pkg::value_type  rsp_front_value,
   input  deq_pkg::value_type  rsp_rear_value,
   input  deq_pkg::count_type  rsp_count,
   input  deq_pkg::status_type rsp_status,
   output int                  error_count,
   output int                  pending_count,
   output int                  checked_count,
   output int                  full_hits,
   output int                  empty_hits
);
   import deq_pkg::*;

   localparam int PRINT_LIMIT = 40;

   typedef struct packed {
      value_type  front_value;
      value_type  rear_value;
      count_type  count;
      status_type status;
   } deque_view_type;

   // shadow copy of the queue contents and pointers
   value_type      shadow_slots [DEPTH];
   int             shadow_front = 0;
   int             shadow_occ   = 0;
   deque_view_type expected_views [$];

   int errors_seen  = 0;
   int pending_seen = 0;
   int checked_seen = 0;
   int full_seen    = 0;
   int empty_seen   = 0;

   assign error_count   = errors_seen;
   assign pending_count = pending_seen;
   assign checked_count = checked_seen;
   assign full_hits     = full_seen;
   assign empty_hits    = empty_seen;

   function automatic deque_view_type deque_update(mode_type op, value_type val);
      deque_view_type view;
      view.status = STATUS_DONE;
      if (op == MODE_PUSH_FRONT || op == MODE_PUSH_REAR) begin
         if (shadow_occ >= DEPTH) begin
            view.status = STATUS_PUSH_FULL;
         end else if (op == MODE_PUSH_FRONT) begin
            shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
            shadow_slots[shadow_front] = val;
            shadow_occ++;
         end else begin
            shadow_slots[(shadow_front + shadow_occ) % DEPTH] = val;
            shadow_occ++;
         end
      end else begin
         if (shadow_occ == 0) begin
            view.status = STATUS_POP_EMPTY;
         end else if (op == MODE_POP_FRONT) begin
            shadow_front = (shadow_front + 1) % DEPTH;
            shadow_occ--;
         end else begin
            shadow_occ--;
         end
      end
      if (shadow_occ == 0) begin
         view.front_value = '0;
         view.rear_value  = '0;
      end else begin
         view.front_value = shadow_slots[shadow_front];
         view.rear_value  = shadow_slots[(shadow_front + shadow_occ - 1) % DEPTH];
      end
      view.count = count_type'(shadow_occ);
      return view;
   endfunction

   task automatic report_mismatch(string msg);
      errors_seen++;
      if (errors_seen <= PRINT_LIMIT)
         $display("mismatch at result %0d: %s", checked_seen, msg);
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
   endtask

   always @(posedge clock) begin
      deque_view_type want;
      if (reset) begin
         shadow_front = 0;
         shadow_occ   = 0;
         expected_views.delete();
      end else begin
         // take the result first so an item accepted at this edge never pairs with it
         if (rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
            if (expected_views.size() == 0) begin
               report_mismatch("result with no item outstanding");
            end else begin
               want = expected_views[0];
               expected_views.delete(0);
               check_field("front_value", rsp_front_value, want.front_value);
               check_field("rear_value", rsp_rear_value, want.rear_value);
               check_field("count", 32'(rsp_count), 32'(want.count));
               check_field("status", 32'(rsp_status), 32'(want.status));
            end
            checked_seen++;
         end
         if (req_valid === 1'b1 && req_ready === 1'b1) begin
            want = deque_update(req_mode, req_value);
            if (want.status == STATUS_PUSH_FULL) full_seen++;
            if (want.status == STATUS_POP_EMPTY) empty_seen++;
            expected_views.push_back(want);
         end
      end
      pending_seen <= expected_views.size();
   end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
   import deq_pkg::*;

   localparam int RESET_CYCLES = 7;
   localparam int RANDOM_ITEMS = 1000;
   localparam int HOLD_AFTER   = 300;    // results taken before the long receiver hold-off
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 8;      // idle clocks after the final drain
   localparam int CYCLE_LIMIT  = 400000;

   logic clock = 1'b0;
   logic reset;
   int   cycle_count = 0;
   int   sent_by_mode [4];
   bit   sender_quiet;

   int error_count;
   int pending_count;
   int checked_count;
   int full_hits;
   int empty_hits;

   deq_req_if req_if ();
   deq_rsp_if rsp_if ();

   double_ended_queue i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   // Watch both channels, predict every result and compare.
   deque_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_if.valid),
      .req_ready       (req_if.ready),
      .req_mode        (req_if.mode),
      .req_value       (req_if.value),
      .rsp_valid       (rsp_if.valid),
      .rsp_ready       (rsp_if.ready),
      .rsp_front_value (rsp_if.front_value),
      .rsp_rear_value  (rsp_if.rear_value),
      .rsp_count       (rsp_if.count),
      .rsp_status      (rsp_if.status),
      .error_count     (error_count),
      .pending_count   (pending_count),
      .checked_count   (checked_count),
      .full_hits       (full_hits),
      .empty_hits      (empty_hits)
   );

   always #1 clock = ~clock;

   // Idle length: mostly none or short, now and then a long one.
   function automatic int idle_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      if (pick < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Push values: lean on the extremes, otherwise any 32-bit pattern.
   function automatic value_type pick_value();
      case ($urandom_range(0, 9))
         0: return value_type'(32'h8000_0000);
         1: return value_type'(32'h7fff_ffff);
         2: return '0;
         3: return '1;
         default: return value_type'($urandom);
      endcase
   endfunction

   // Pick an operation, pushing with the given percentage.
   function automatic mode_type pick_mode(int push_pct);
      if ($urandom_range(0, 99) < push_pct)
         return $urandom_range(0, 1) ? MODE_PUSH_REAR : MODE_PUSH_FRONT;
      return $urandom_range(0, 1) ? MODE_POP_REAR : MODE_POP_FRONT;
   endfunction

   // Offer one item, hold it until accepted, then idle unless the stretch is quiet.
   task automatic send_op(mode_type op, value_type val);
      int gap;
      req_if.valid <= 1'b1;
      req_if.mode  <= op;
      req_if.value <= val;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      sent_by_mode[op]++;
      gap = sender_quiet ? 0 : idle_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and hold until every outstanding item has its result back.
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // Timeout: end the run at a generous cycle limit.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   // Receiver: random stalls, quiet epochs, and one long hold-off so the block backs up.
   initial begin
      int  stall_left;
      int  taken;
      int  epoch;
      bit  idle_on;
      bit  hold_done;
      stall_left = 0;
      taken      = 0;
      epoch      = 0;
      idle_on    = 1'b1;
      hold_done  = 1'b0;
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (epoch % 256 == 0) idle_on = ($urandom_range(0, 3) != 0);
         if (!hold_done && taken >= HOLD_AFTER) begin
            stall_left = HOLD_CYCLES;
            hold_done  = 1'b1;
         end
         if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready <= 1'b1;
            if (idle_on && $urandom_range(0, 99) < 25) stall_left = idle_gap();
         end
         @(posedge clock);
         if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) taken++;
         epoch++;
      end
   end

   // Sender: directed corners, then biased random segments, then verdict.
   initial begin
      int seg_len;
      int push_pct;
      int sent;
      bit paused;
      foreach (sent_by_mode[m]) sent_by_mode[m] = 0;
      reset        <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.mode  <= MODE_PUSH_FRONT;
      req_if.value <= '0;
      sender_quiet = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // pops on an empty queue are ignored
      send_op(MODE_POP_FRONT, value_type'($urandom));
      send_op(MODE_POP_REAR, value_type'($urandom));
      // single value popped from the rear empties the queue
      send_op(MODE_PUSH_REAR, value_type'(32'h7fff_ffff));
      send_op(MODE_POP_REAR, '0);
      // single value popped from the front; front pointer stays where it lands
      send_op(MODE_PUSH_FRONT, value_type'(32'h8000_0000));
      send_op(MODE_POP_FRONT, '1);
      // fill from both ends, wrapping the front pointer below slot zero
      for (int i = 0; i < DEPTH; i++) begin
         if (i % 2 == 0)
            send_op(MODE_PUSH_FRONT, value_type'(32'h8000_0000 + i));
         else
            send_op(MODE_PUSH_REAR, value_type'(32'h7fff_ffff - i));
      end
      // pushes on a full queue are dropped
      send_op(MODE_PUSH_FRONT, '1);
      send_op(MODE_PUSH_REAR, '0);
      send_op(MODE_POP_REAR, '0);
      send_op(MODE_POP_FRONT, '0);
      wait_drained();

      // random segments alternate between filling, draining and balanced traffic
      sent   = 0;
      paused = 1'b0;
      while (sent < RANDOM_ITEMS) begin
         seg_len = $urandom_range(20, 60);
         case ($urandom_range(0, 2))
            0: push_pct = 80;
            1: push_pct = 20;
            default: push_pct = 50;
         endcase
         sender_quiet = ($urandom_range(0, 3) == 0);
         repeat (seg_len) begin
            send_op(pick_mode(push_pct), pick_value());
            sent++;
         end
         if (!paused && sent >= RANDOM_ITEMS / 2) begin
            wait_drained();
            paused = 1'b1;
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d push front, %0d push rear, %0d pop front, %0d pop rear items",
               sent_by_mode[MODE_PUSH_FRONT], sent_by_mode[MODE_PUSH_REAR],
               sent_by_mode[MODE_POP_FRONT], sent_by_mode[MODE_POP_REAR]);
      $display("checked %0d results: %0d pushes dropped on full, %0d pops ignored on empty",
               checked_count, full_hits, empty_hits);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
